// ----- rtl/fsubm_pkg.sv -----
`timescale 1ns / 1ps

package fsubm_pkg;

    localparam int PATTERN_MAX     = 64;
    localparam int TEXT_MAX        = 128;

    localparam int PATTERN_INDEX_W = 6;
    localparam int CHAR_W          = 8;
    localparam int LEN_W           = 7;
    localparam int START_W         = 7;
    localparam int POS_W           = $clog2(TEXT_MAX + 1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEXT = 1'b1;

    typedef struct packed {
        logic                       operation;
        logic [PATTERN_INDEX_W-1:0] pattern_index;
        logic [CHAR_W-1:0]          char_in;
        logic                       end_of_text;
    } in_word_t;

    typedef struct packed {
        logic               found;
        logic [START_W-1:0] match_start;
        logic               text_overflow;
    } out_word_t;

    // control broadcast from the top level to every cell of the row
    typedef struct packed {
        logic                       load;
        logic [PATTERN_INDEX_W-1:0] load_idx;
        logic                       step;
        logic                       clear;
        logic [CHAR_W-1:0]          ch;
        logic [LEN_W-1:0]           len;
    } fsubm_ctrl_t;

endpackage

// ----- rtl/fsubm_cell.sv -----
`timescale 1ns / 1ps

module fsubm_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fsubm_pkg::fsubm_ctrl_t              ctrl,
    input  logic [fsubm_pkg::PATTERN_INDEX_W-1:0] cell_idx,
    input  logic                                pm_in,
    output logic                                pm_out,
    output logic                                hit
);
    import fsubm_pkg::*;

    logic [CHAR_W-1:0] pat_reg;
    logic              pm_reg;
    logic              pm_next;
    logic              pm_step;
    logic              in_use;
    logic              is_last;

    assign in_use  = {1'b0, cell_idx} < ctrl.len;
    assign is_last = {1'b0, cell_idx} == (ctrl.len - LEN_W'(1));

    // partial match extends the neighbor's prefix by this cell's character
    assign pm_step = pm_in && in_use && (pat_reg == ctrl.ch);

    always_comb begin
        pm_next = pm_reg;
        if (ctrl.clear) begin
            pm_next = 1'b0;
        end else if (ctrl.step) begin
            pm_next = pm_step;
        end
    end

    assign hit    = ctrl.step && pm_step && is_last;
    assign pm_out = pm_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pm_reg <= 1'b0;
        end else begin
            pm_reg <= pm_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load && (ctrl.load_idx == cell_idx)) begin
            pat_reg <= ctrl.ch;
        end
    end

endmodule

// ----- rtl/fsubm_chain.sv -----
`timescale 1ns / 1ps

module fsubm_chain (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  fsubm_pkg::fsubm_ctrl_t ctrl,
    output logic                   hit
);
    import fsubm_pkg::*;

    logic [PATTERN_MAX-1:0] pm_q;
    logic [PATTERN_MAX-1:0] pm_link;
    logic [PATTERN_MAX-1:0] hits;

    // cell 0 always starts a new candidate
    assign pm_link = {pm_q[PATTERN_MAX-2:0], 1'b1};

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        fsubm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .cell_idx (PATTERN_INDEX_W'(k)),
            .pm_in    (pm_link[k]),
            .pm_out   (pm_q[k]),
            .hit      (hits[k])
        );
    end

    assign hit = |hits;

endmodule

// ----- rtl/first_substring_match.sv -----
`timescale 1ns / 1ps

// channel  | direction | handshake         | word
// s_       | in        | s_valid / s_ready | fsubm_pkg::in_word_t
// m_       | out       | m_valid / m_ready | fsubm_pkg::out_word_t
// cfg_     | in        | cfg_we            | pattern_length, 7 bits
//
// one word per cycle: each cell of the 64-cell row updates its match bit
// from its neighbor in the cycle the word is accepted; the result is
// registered and shows up in the cycle after the word that caused it.
// s_ready drops only while a result sits in the output register and
// m_ready is low. reset is synchronous, active low; the pattern store is
// not reset and must be loaded before text is sent.

module first_substring_match (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [fsubm_pkg::LEN_W-1:0]        cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  fsubm_pkg::in_word_t                s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output fsubm_pkg::out_word_t               m_data
);
    import fsubm_pkg::*;

    logic [LEN_W-1:0] pattern_length_reg;
    logic [LEN_W-1:0] len_eff;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             matched_reg, matched_next;
    logic             overflow_reg, overflow_next;
    logic             m_valid_reg, m_valid_next;
    out_word_t        m_data_reg, m_data_next;

    fsubm_ctrl_t ctrl;
    logic        accept;
    logic        text_word;
    logic        active;
    logic        hit;
    logic        match;
    logic        last;
    logic [POS_W-1:0] start_full;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        priority if (pattern_length_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (pattern_length_reg > LEN_W'(PATTERN_MAX)) begin
            len_eff = LEN_W'(PATTERN_MAX);
        end else begin
            len_eff = pattern_length_reg;
        end
    end

    assign text_word = accept && (s_data.operation == OP_TEXT);
    assign active    = text_word && !matched_reg && !overflow_reg;
    assign last      = text_word && s_data.end_of_text;

    always_comb begin
        ctrl.load     = accept && (s_data.operation == OP_LOAD)
                        && ({1'b0, s_data.pattern_index} < (PATTERN_INDEX_W + 1)'(PATTERN_MAX));
        ctrl.load_idx = s_data.pattern_index;
        ctrl.step     = active && (pos_reg < POS_W'(TEXT_MAX));
        ctrl.clear    = last;
        ctrl.ch       = s_data.char_in;
        ctrl.len      = len_eff;
    end

    fsubm_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .hit     (hit)
    );

    assign match      = ctrl.step && hit;
    assign start_full = pos_reg + POS_W'(1) - POS_W'(len_eff);

    always_comb begin
        pos_next      = pos_reg;
        matched_next  = matched_reg || match;
        overflow_next = overflow_reg || (active && !ctrl.step);
        if (ctrl.step) begin
            pos_next = pos_reg + POS_W'(1);
        end

        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (match) begin
            m_valid_next              = 1'b1;
            m_data_next.found         = 1'b1;
            m_data_next.match_start   = start_full[START_W-1:0];
            m_data_next.text_overflow = 1'b0;
        end else if (last && !matched_reg) begin
            m_valid_next              = 1'b1;
            m_data_next.found         = 1'b0;
            m_data_next.match_start   = '0;
            m_data_next.text_overflow = overflow_next;
        end

        if (last) begin
            pos_next      = '0;
            matched_next  = 1'b0;
            overflow_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= LEN_W'(1);
            pos_reg            <= '0;
            matched_reg        <= 1'b0;
            overflow_reg       <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_we) begin
                pattern_length_reg <= cfg_wdata;
            end
            pos_reg      <= pos_next;
            matched_reg  <= matched_next;
            overflow_reg <= overflow_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    a_found_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.found |-> !m_data.text_overflow)
        else $error("found result carries overflow");

    a_match_latched: assert property (@(posedge aclk) disable iff (!aresetn)
        match && !last |=> matched_reg)
        else $error("match not remembered");

    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(TEXT_MAX))
        else $error("text position past limit");

    a_match_excl_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(matched_reg && overflow_reg))
        else $error("match and overflow both set");

    a_result_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        last && !matched_reg |=> m_valid)
        else $error("end of text gave no result");

endmodule
